// ===== rtl/nd_pkg.sv =====
// Shared types, constants and the denomination table of the note dispenser.
`default_nettype none

package nd_pkg;

  localparam int NUM_DENOMS  = 7;
  localparam int IDX_BITS    = $clog2(NUM_DENOMS);
  localparam int DENOM_BITS  = 7;
  localparam int FIELD_BITS  = 16;
  localparam int IN_AMT_BITS = 20;
  localparam int DIV_STEPS   = 8;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int AMOUNT_BITS_DEF = 20;

  typedef enum logic [1:0] {
    ST_DISPENSED = 2'd0,
    ST_SHORT     = 2'd1,
    ST_INVALID   = 2'd2,
    ST_DEPOSIT   = 2'd3
  } status_t;

  typedef struct packed {
    logic                   kind;
    logic [IN_AMT_BITS-1:0] amount;
    logic [FIELD_BITS-1:0]  add_100;
    logic [FIELD_BITS-1:0]  add_50;
    logic [FIELD_BITS-1:0]  add_20;
    logic [FIELD_BITS-1:0]  add_10;
    logic [FIELD_BITS-1:0]  add_5;
    logic [FIELD_BITS-1:0]  add_2;
    logic [FIELD_BITS-1:0]  add_1;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [FIELD_BITS-1:0] used_100;
    logic [FIELD_BITS-1:0] used_50;
    logic [FIELD_BITS-1:0] used_20;
    logic [FIELD_BITS-1:0] used_10;
    logic [FIELD_BITS-1:0] used_5;
    logic [FIELD_BITS-1:0] used_2;
    logic [FIELD_BITS-1:0] used_1;
  } out_item_t;

  // Note value by stock slot, largest first.
  function automatic logic [DENOM_BITS-1:0] denom_of(input logic [IDX_BITS-1:0] idx);
    logic [DENOM_BITS-1:0] val;
    case (idx)
      3'd0:    val = 7'd100;
      3'd1:    val = 7'd50;
      3'd2:    val = 7'd20;
      3'd3:    val = 7'd10;
      3'd4:    val = 7'd5;
      3'd5:    val = 7'd2;
      3'd6:    val = 7'd1;
      default: val = 7'd1;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/note_dispenser_greedy_core.sv =====
// Top level of the note dispenser: stock RAM, greedy withdraw sequencer and deposit path.
//
//   channel   dir  handshake              payload
//   -------   ---  ---------------------  ----------------------------------------
//   command   in   start && !busy         item   (kind, amount, add_100 .. add_1)
//   result    out  done, one cycle        result (status, used_100 .. used_1)
//
// A deposit reads and writes back each of the seven stock slots in turn
// through the single RAM port pair. A withdraw runs a greedy pass over the
// seven slots, one shared-divider division per note, then does seven commit
// writes when it succeeds; the shared divider and the one-read RAM set its pace.
// A zero amount is answered in the cycle after accept.
// Reset clears the sequencer and the per-slot valid bits; a slot never
// written reads as zero stock, so no clearing pass is needed.
// The receiver cannot stall: each result beat shows for one cycle, and busy
// drops with it, so the next command can be taken during the result beat.
`default_nettype none

module note_dispenser_greedy_core #(
  parameter int COUNT_BITS  = nd_pkg::COUNT_BITS_DEF,
  parameter int AMOUNT_BITS = nd_pkg::AMOUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire nd_pkg::in_item_t  item,
  output logic                   busy,
  output logic                   done,
  output nd_pkg::out_item_t      result
);

  import nd_pkg::*;

  localparam int PROD_W = COUNT_BITS + DENOM_BITS;
  localparam int W      = (AMOUNT_BITS > PROD_W) ? AMOUNT_BITS : PROD_W;
  localparam int SUM_W  = ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(NUM_DENOMS - 1);

  typedef enum logic [2:0] {
    IDLE,
    DEP_RD,
    DEP_WR,
    WD_RD,
    WD_DIV,
    WD_TAKE,
    COMMIT
  } state_t;

  state_t                  state;
  in_item_t                item_q;
  logic [IDX_BITS-1:0]     idx;
  logic [AMOUNT_BITS-1:0]  rest;
  logic [PROD_W-1:0]       prod;
  logic [COUNT_BITS-1:0]   take_q [NUM_DENOMS];
  logic [COUNT_BITS-1:0]   left_q [NUM_DENOMS];
  logic [NUM_DENOMS-1:0]   vld;
  logic                    rd_vld;

  logic                    ram_we;
  logic                    ram_re;
  logic [COUNT_BITS-1:0]   ram_wdata;
  logic [COUNT_BITS-1:0]   ram_rdata;
  logic [COUNT_BITS-1:0]   stock_rd;

  logic [AMOUNT_BITS-1:0]  amt_in;
  logic [FIELD_BITS-1:0]   add_sel;
  logic [SUM_W-1:0]        sum_v;
  logic [COUNT_BITS-1:0]   dep_v;
  logic [PROD_W-1:0]       prod_v;
  logic [W-1:0]            fit_w;
  logic [COUNT_BITS-1:0]   take_v;
  logic [COUNT_BITS-1:0]   left_v;
  logic [AMOUNT_BITS-1:0]  rest_v;

  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [AMOUNT_BITS-1:0]  div_quot;
  logic [DENOM_BITS-1:0]   div_rem;

  // Result beat that carries only a status, with every note count at zero.
  function automatic out_item_t status_beat(input status_t st);
    out_item_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // Stock RAM: one slot per note, largest first. The sequencer never reads a
  // slot before its pending write has landed, so no forwarding is needed.
  nd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_DENOMS)
  ) u_stock (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  nd_div #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rest),
    .divisor  (denom_of(idx)),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign busy      = (state != IDLE);
  assign ram_re    = (state == DEP_RD) || (state == WD_RD);
  assign ram_we    = (state == DEP_WR) || (state == COMMIT);
  assign div_start = (state == WD_RD);

  // Unwritten slots read as empty.
  assign stock_rd = rd_vld ? ram_rdata : '0;
  assign amt_in   = AMOUNT_BITS'(item.amount);

  always_comb begin
    case (idx)
      3'd0:    add_sel = item_q.add_100;
      3'd1:    add_sel = item_q.add_50;
      3'd2:    add_sel = item_q.add_20;
      3'd3:    add_sel = item_q.add_10;
      3'd4:    add_sel = item_q.add_5;
      3'd5:    add_sel = item_q.add_2;
      3'd6:    add_sel = item_q.add_1;
      default: add_sel = '0;
    endcase
  end

  // Deposit: add and saturate at the count ceiling.
  assign sum_v = SUM_W'(stock_rd) + SUM_W'(add_sel);
  assign dep_v = (sum_v > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum_v);

  assign ram_wdata = (state == COMMIT) ? left_q[idx] : dep_v;

  // Value of the whole stock of this note; registered before the subtract.
  assign prod_v = PROD_W'(stock_rd) * PROD_W'(denom_of(idx));

  // Greedy pick: take as many as fit, capped by stock.
  always_comb begin
    fit_w = W'(div_quot);
    if (fit_w <= W'(stock_rd)) begin
      take_v = COUNT_BITS'(div_quot);
      rest_v = AMOUNT_BITS'(div_rem);
    end else begin
      take_v = stock_rd;
      rest_v = AMOUNT_BITS'(W'(rest) - W'(prod));
    end
    left_v = stock_rd - take_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      done   <= 1'b0;
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ram_re) begin
        rd_vld <= vld[idx];
      end
      if (ram_we) begin
        vld[idx] <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (start) begin
            item_q <= item;
            idx    <= '0;
            rest   <= amt_in;
            if (item.kind) begin
              state <= DEP_RD;
            end else if (amt_in == '0) begin
              // Zero amount: reject at once, stock untouched.
              done   <= 1'b1;
              result <= status_beat(ST_INVALID);
            end else begin
              state <= WD_RD;
            end
          end
        end
        DEP_RD: begin
          state <= DEP_WR;
        end
        DEP_WR: begin
          if (idx == LAST_IDX) begin
            done   <= 1'b1;
            result <= status_beat(ST_DEPOSIT);
            state  <= IDLE;
          end else begin
            idx   <= idx + IDX_BITS'(1);
            state <= DEP_RD;
          end
        end
        WD_RD: begin
          state <= WD_DIV;
        end
        WD_DIV: begin
          prod <= prod_v;
          if (div_done) begin
            state <= WD_TAKE;
          end
        end
        WD_TAKE: begin
          take_q[idx] <= take_v;
          left_q[idx] <= left_v;
          rest        <= rest_v;
          if (idx == LAST_IDX) begin
            idx <= '0;
            if (rest_v == '0) begin
              state <= COMMIT;
            end else begin
              // Greedy pass left a remainder: drop the picks.
              done   <= 1'b1;
              result <= status_beat(ST_SHORT);
              state  <= IDLE;
            end
          end else begin
            idx   <= idx + IDX_BITS'(1);
            state <= WD_RD;
          end
        end
        COMMIT: begin
          if (idx == LAST_IDX) begin
            done            <= 1'b1;
            result.status   <= ST_DISPENSED;
            result.used_100 <= FIELD_BITS'(take_q[0]);
            result.used_50  <= FIELD_BITS'(take_q[1]);
            result.used_20  <= FIELD_BITS'(take_q[2]);
            result.used_10  <= FIELD_BITS'(take_q[3]);
            result.used_5   <= FIELD_BITS'(take_q[4]);
            result.used_2   <= FIELD_BITS'(take_q[5]);
            result.used_1   <= FIELD_BITS'(take_q[6]);
            state           <= IDLE;
          end else begin
            idx <= idx + IDX_BITS'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Every accepted command either starts work or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

  // A result beat only follows a command or work in flight.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result beat without a command");

  // A dispense is reported only after the commit pass.
  a_dispense_commit: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_DISPENSED) |-> ($past(state) == COMMIT))
    else $error("dispense reported without commit");

  // The divider is never restarted mid-division.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // Only a dispense carries note counts.
  a_used_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_DISPENSED) |->
      (result.used_100 == '0 && result.used_50 == '0 && result.used_20 == '0 &&
       result.used_10 == '0 && result.used_5 == '0 && result.used_2 == '0 &&
       result.used_1 == '0))
    else $error("note counts on a non-dispense result");

endmodule

`default_nettype wire

// ===== rtl/nd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 7
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nd_div.sv =====
// Restoring divider of a remainder by a small note value, DIV_STEPS quotient bits per busy cycle.
`default_nettype none

module nd_div #(
  parameter int AMOUNT_BITS = nd_pkg::AMOUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [AMOUNT_BITS-1:0]        dividend,
  input  wire logic [nd_pkg::DENOM_BITS-1:0] divisor,
  output logic                               busy,
  output logic                               done,
  output logic      [AMOUNT_BITS-1:0]        quot,
  output logic      [nd_pkg::DENOM_BITS-1:0] rem
);

  import nd_pkg::*;

  localparam int NCYC  = (AMOUNT_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD   = NCYC * DIV_STEPS;
  localparam int CNT_W = $clog2(NCYC + 1);

  logic [PAD-1:0]        sh;
  logic [PAD-1:0]        sh_next;
  logic [DENOM_BITS-1:0] r;
  logic [DENOM_BITS-1:0] r_next;
  logic [DENOM_BITS-1:0] dvs;
  logic [DENOM_BITS:0]   trial;
  logic [CNT_W-1:0]      cnt;

  // Partial remainder stays below the divisor, so every step is narrow.
  always_comb begin
    sh_next = sh;
    r_next  = r;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {r_next, sh_next[PAD-1]};
      sh_next = {sh_next[PAD-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial      = trial - {1'b0, dvs};
        sh_next[0] = 1'b1;
      end
      r_next = trial[DENOM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(NCYC);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
    if (start) begin
      sh  <= PAD'(dividend);
      r   <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      sh <= sh_next;
      r  <= r_next;
    end
  end

  assign busy = (cnt != '0);
  assign quot = AMOUNT_BITS'(sh);
  assign rem  = r;

endmodule

`default_nettype wire

// ===== sim/note_dispenser_greedy_core_tb.sv =====
// Self-checking testbench for the greedy note dispenser core.
`timescale 1ns / 100ps

module note_dispenser_greedy_core_tb;
  import nd_pkg::*;

  localparam int          COUNT_BITS  = COUNT_BITS_DEF;
  localparam longint      STOCK_MAX   = (64'd1 << COUNT_BITS) - 1;
  localparam logic [19:0] AMOUNT_FULL = 20'hFFFFF;
  localparam int          RANDOM_BEATS = 450;
  localparam int          DRAIN_CYCLES = 80;  // quiet tail after the last predicted result

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  note_dispenser_greedy_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // Predicted inventory, largest note first, and the note values that go with it.
  longint unsigned stock_cnt [NUM_DENOMS];
  int unsigned     note_value [NUM_DENOMS] = '{100, 50, 20, 10, 5, 2, 1};

  in_item_t  cmd_q[$];     // commands waiting to be driven
  out_item_t payout_q[$];  // predicted result beats, oldest first
  int        gap_left   = 0;
  logic      beat_taken = 1'b0;
  int        mismatches = 0;

  initial begin
    for (int k = 0; k < NUM_DENOMS; k++) stock_cnt[k] = 0;
  end

  // Deposited count for a stock slot.
  function automatic longint unsigned add_at(input in_item_t it, input int k);
    case (k)
      0: return 64'(it.add_100);
      1: return 64'(it.add_50);
      2: return 64'(it.add_20);
      3: return 64'(it.add_10);
      4: return 64'(it.add_5);
      5: return 64'(it.add_2);
      default: return 64'(it.add_1);
    endcase
  endfunction

  // Dispensed count for a stock slot.
  function automatic logic [FIELD_BITS-1:0] used_at(input out_item_t r, input int k);
    case (k)
      0: return r.used_100;
      1: return r.used_50;
      2: return r.used_20;
      3: return r.used_10;
      4: return r.used_5;
      5: return r.used_2;
      default: return r.used_1;
    endcase
  endfunction

  // Apply one command to the predicted inventory and work out its result beat.
  task automatic compute_payout(input in_item_t it, output out_item_t res);
    longint unsigned rest;
    longint unsigned fit;
    longint unsigned sum;
    longint unsigned take [NUM_DENOMS];
    res = '0;
    if (it.kind) begin
      // Deposit: add each count, saturate at the counter maximum.
      for (int k = 0; k < NUM_DENOMS; k++) begin
        sum = stock_cnt[k] + add_at(it, k);
        stock_cnt[k] = (sum > STOCK_MAX) ? STOCK_MAX : sum;
      end
      res.status = ST_DEPOSIT;
    end else if (it.amount == '0) begin
      res.status = ST_INVALID;
    end else begin
      // Greedy pass from the largest note down; commit only on an exact cover.
      rest = 64'(it.amount);
      for (int k = 0; k < NUM_DENOMS; k++) begin
        fit     = rest / note_value[k];
        take[k] = (fit < stock_cnt[k]) ? fit : stock_cnt[k];
        rest    = rest - take[k] * note_value[k];
      end
      if (rest != 0) begin
        res.status = ST_SHORT;
      end else begin
        for (int k = 0; k < NUM_DENOMS; k++) stock_cnt[k] = stock_cnt[k] - take[k];
        res.status   = ST_DISPENSED;
        res.used_100 = take[0][FIELD_BITS-1:0];
        res.used_50  = take[1][FIELD_BITS-1:0];
        res.used_20  = take[2][FIELD_BITS-1:0];
        res.used_10  = take[3][FIELD_BITS-1:0];
        res.used_5   = take[4][FIELD_BITS-1:0];
        res.used_2   = take[5][FIELD_BITS-1:0];
        res.used_1   = take[6][FIELD_BITS-1:0];
      end
    end
  endtask

  // Deposit command; the amount field carries junk since the core ignores it.
  function automatic in_item_t deposit_item(input int unsigned c100, c50, c20, c10,
                                            c5, c2, c1);
    in_item_t it;
    it.kind    = 1'b1;
    it.amount  = IN_AMT_BITS'($urandom_range(0, AMOUNT_FULL));
    it.add_100 = FIELD_BITS'(c100);
    it.add_50  = FIELD_BITS'(c50);
    it.add_20  = FIELD_BITS'(c20);
    it.add_10  = FIELD_BITS'(c10);
    it.add_5   = FIELD_BITS'(c5);
    it.add_2   = FIELD_BITS'(c2);
    it.add_1   = FIELD_BITS'(c1);
    return it;
  endfunction

  // Withdraw command; the deposit counts carry junk since the core ignores them.
  function automatic in_item_t withdraw_item(input logic [IN_AMT_BITS-1:0] amt);
    in_item_t it;
    it.kind    = 1'b0;
    it.amount  = amt;
    it.add_100 = FIELD_BITS'($urandom);
    it.add_50  = FIELD_BITS'($urandom);
    it.add_20  = FIELD_BITS'($urandom);
    it.add_10  = FIELD_BITS'($urandom);
    it.add_5   = FIELD_BITS'($urandom);
    it.add_2   = FIELD_BITS'($urandom);
    it.add_1   = FIELD_BITS'($urandom);
    return it;
  endfunction

  // Mostly small deposits so the stock can run dry; now and then a huge one.
  function automatic int unsigned rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 5);
    if (r < 85) return $urandom_range(0, 255);
    if (r < 97) return $urandom_range(0, 16'hFFFF);
    return 16'hFFFF;
  endfunction

  function automatic logic [IN_AMT_BITS-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 45) return IN_AMT_BITS'($urandom_range(1, 400));
    if (r < 70) return IN_AMT_BITS'($urandom_range(1, 20000));
    if (r < 92) return IN_AMT_BITS'($urandom_range(0, AMOUNT_FULL));
    return AMOUNT_FULL - IN_AMT_BITS'($urandom_range(0, 255));
  endfunction

  // Idle cycles after a command: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  // Driver: change inputs on the falling edge; hold a command until its beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the current command
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (cmd_q.size() != 0) begin
      item     <= cmd_q.pop_front();
      start    <= 1'b1;
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: sample on the rising edge. Check a result beat against the oldest
  // prediction first, then predict for a command taken at the same edge.
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (done) begin
        if (payout_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          want = payout_q.pop_front();
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     result.status);
            mismatches++;
          end
          for (int k = 0; k < NUM_DENOMS; k++) begin
            if (used_at(result, k) !== used_at(want, k)) begin
              $display("%0t: used_%0d expected %0d got %0d", $time, note_value[k],
                       used_at(want, k), used_at(result, k));
              mismatches++;
            end
          end
        end
      end
      if (start && !busy) begin
        compute_payout(item, fresh);
        payout_q.push_back(fresh);
      end
      beat_taken <= start && !busy;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    in_item_t it;
    int       r;

    // Directed: empty stock, greedy miss, exact covers, ignored fields, saturation.
    cmd_q.push_back(withdraw_item(20'd0));        // zero amount on empty stock
    cmd_q.push_back(withdraw_item(20'd1));        // nothing to pay with
    cmd_q.push_back(deposit_item(0, 1, 3, 0, 0, 0, 0));
    cmd_q.push_back(withdraw_item(20'd60));       // greedy takes the 50 and misses
    cmd_q.push_back(withdraw_item(20'd110));      // exactly the whole stock, paid out
    cmd_q.push_back(withdraw_item(20'd50));
    cmd_q.push_back(withdraw_item(20'd60));       // stock is empty, no 20s left
    cmd_q.push_back(withdraw_item(20'd5));        // stock is empty again
    it = deposit_item(0, 0, 0, 0, 0, 0, 0);
    it.amount = AMOUNT_FULL;                      // amount must not matter on a deposit
    cmd_q.push_back(it);
    cmd_q.push_back(deposit_item(1, 1, 1, 1, 1, 1, 1));
    it = withdraw_item(20'd188);                  // one of each note
    it.add_100 = '1; it.add_50 = '1; it.add_20 = '1; it.add_10 = '1;
    it.add_5   = '1; it.add_2  = '1; it.add_1  = '1;
    cmd_q.push_back(it);
    cmd_q.push_back(deposit_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF));
    cmd_q.push_back(deposit_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF));  // every count saturates
    cmd_q.push_back(deposit_item(1, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(withdraw_item(AMOUNT_FULL));
    cmd_q.push_back(withdraw_item(20'd0));
    cmd_q.push_back(withdraw_item(20'd1));
    cmd_q.push_back(withdraw_item(20'd3));
    cmd_q.push_back(withdraw_item(20'h80000));
    cmd_q.push_back(withdraw_item(AMOUNT_FULL));

    // Random: mixed deposits and withdraws, biased toward a stock that runs low.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        cmd_q.push_back(deposit_item(rand_count(), rand_count(), rand_count(),
                                     rand_count(), rand_count(), rand_count(),
                                     rand_count()));
      else
        cmd_q.push_back(withdraw_item(rand_amount()));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every command taken, every prediction met, then a quiet tail.
    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (payout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nd_pkg.sv
rtl/nd_ram.sv
rtl/nd_div.sv
rtl/note_dispenser_greedy_core.sv
sim/note_dispenser_greedy_core_tb.sv
